// ----- rtl/core/nsp_pkg.sv -----
// ----------------------------------------------------------------------------
// nsp_pkg: shared types and constants of the palette colorizer
// Request kinds, register indexes, queue sizes and the records that move
// between the front end, the work queue and the back end.
// ----------------------------------------------------------------------------
package nsp_pkg;

	localparam int LINE_DEPTH_DEF    = 4096;
	localparam int PALETTE_DEPTH_DEF = 16;

	localparam int IDX_W    = 12;
	localparam int DATA_W   = 24;
	localparam int ROW_W    = 12;
	localparam int SCALE_W  = 24;
	localparam int NCOL_W   = 5;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = IDX_W + SCALE_W;
	localparam int SRC_W    = PROD_W - FRAC_W;
	localparam int LINES_W  = 13;
	localparam int PIX_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [LINES_W-1:0] LINES_MAX = '1;

	localparam int MID_DEPTH  = 4;
	localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS = 2'd1;

	typedef enum logic [1:0] {
		REQ_PAL_WR    = 2'd0,
		REQ_SRC_WR    = 2'd1,
		REQ_ROW_START = 2'd2,
		REQ_PIXEL     = 2'd3
	} req_e_t;

	typedef struct packed {
		req_e_t             req;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  data;
		logic [SRC_W-1:0]   scaled;
		logic               row_zero;
		logic [1:0]         phase;
	} work_t;

	typedef struct packed {
		logic               take;
		logic [DATA_W-1:0]  rgb;
	} res_t;

	function automatic logic [1:0] mod3_row(input logic [ROW_W-1:0] v);
		logic [4:0] s;
		begin
			s = '0;
			for (int i = 0; i < ROW_W / 2; i++) begin
				s = s + 5'(v[2*i +: 2]);
			end
			if (s >= 5'd12) s = s - 5'd12;
			if (s >= 5'd6)  s = s - 5'd6;
			if (s >= 5'd3)  s = s - 5'd3;
			return s[1:0];
		end
	endfunction

endpackage

// ----- rtl/core/nsp_fifo.sv -----
// ----------------------------------------------------------------------------
// nsp_fifo: small register queue
// Holds records between two parts of the block; reports its fill level so
// the writer can reserve room ahead.
// ----------------------------------------------------------------------------
module nsp_fifo #(
	parameter int  DEPTH = 4,
	parameter type T     = logic [7:0]
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  T                             push_data,
	input  logic                         pop,
	output T                             pop_data,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		begin
			return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

// ----- rtl/core/nsp_front.sv -----
// ----------------------------------------------------------------------------
// nsp_front: request intake and coordinate scaling
// Accepts request beats, scales the column or row by the inverse scale and
// hands a classified work record to the work queue.
// ----------------------------------------------------------------------------
module nsp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [47:0]                      s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic [nsp_pkg::SCALE_W-1:0]      inv_scale,
	input  logic [nsp_pkg::MID_CNT_W-1:0]    mid_count,
	output logic                             work_valid,
	output nsp_pkg::work_t                   work
);

	import nsp_pkg::*;

	logic               accept;
	req_e_t             req;
	logic [IDX_W-1:0]   idx;
	logic [DATA_W-1:0]  data;
	logic [ROW_W-1:0]   row;
	logic [IDX_W-1:0]   operand;
	logic [PROD_W-1:0]  product;
	logic               v_s1;
	work_t              work_s1;

	assign req  = req_e_t'(s_tuser);
	assign idx  = s_tdata[IDX_W-1:0];
	assign data = s_tdata[IDX_W +: DATA_W];
	assign row  = s_tdata[IDX_W + DATA_W +: ROW_W];

	assign s_tready = ((MID_CNT_W + 1)'(mid_count) + (MID_CNT_W + 1)'(v_s1))
		< (MID_CNT_W + 1)'(MID_DEPTH);
	assign accept = s_tvalid && s_tready;

	assign operand = (req == REQ_ROW_START) ? row : idx;
	assign product = PROD_W'(operand) * PROD_W'(inv_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.req      <= req;
			work_s1.idx      <= idx;
			work_s1.data     <= data;
			work_s1.scaled   <= product[PROD_W-1:FRAC_W];
			work_s1.row_zero <= (row == '0);
			work_s1.phase    <= mod3_row(row);
		end
	end

	assign work_valid = v_s1;
	assign work       = work_s1;

endmodule

// ----- rtl/core/nsp_back.sv -----
// ----------------------------------------------------------------------------
// nsp_back: line store, palette and row bookkeeping
// Executes work records in order: table writes, row starts and pixel
// lookups through the line store and the palette.
// ----------------------------------------------------------------------------
module nsp_back #(
	parameter int LINE_DEPTH    = nsp_pkg::LINE_DEPTH_DEF,
	parameter int PALETTE_DEPTH = nsp_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             work_avail,
	input  nsp_pkg::work_t                   work,
	output logic                             work_pop,
	input  logic [nsp_pkg::NCOL_W-1:0]       num_colors,
	input  logic [nsp_pkg::OUT_CNT_W-1:0]    out_count,
	output logic                             res_valid,
	output nsp_pkg::res_t                    res
);

	import nsp_pkg::*;

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [PIX_W-1:0]    line_mem [LINE_DEPTH];
	logic [DATA_W-1:0]   pal_mem [PALETTE_DEPTH];

	logic [LINES_W-1:0]  lines_q;
	logic [1:0]          row_phase_q;
	logic [LINES_W-1:0]  lines_base;
	logic                take;
	logic [LINES_W-1:0]  lines_next;
	logic [AW-1:0]       rd_addr;
	logic                pat_hit;

	logic                v_s1;
	logic                take_s1;
	logic                pix_s1;
	logic [PIX_W-1:0]    line_rd_s1;

	logic                v_s2;
	logic                take_s2;
	logic                col_s2;
	logic [DATA_W-1:0]   pal_rd_s2;
	logic                colored;

	assign work_pop = work_avail &&
		(((OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(v_s1) + (OUT_CNT_W + 1)'(v_s2))
		< (OUT_CNT_W + 1)'(OUT_DEPTH));

	assign lines_base = work.row_zero ? '0 : lines_q;
	assign take       = (work.scaled >= SRC_W'(lines_base));
	assign lines_next = (take && (lines_base != LINES_MAX)) ? lines_base + 1'b1 : lines_base;

	assign rd_addr = (32'(work.scaled) > LINE_DEPTH - 1) ? AW'(LINE_DEPTH - 1)
		: AW'(work.scaled);
	assign pat_hit = ((row_phase_q + work.idx[1:0] + 2'd1) == 2'd0);

	always_ff @(posedge clk) begin
		if (work_pop && work.req == REQ_SRC_WR && 32'(work.idx) < LINE_DEPTH) begin
			line_mem[AW'(work.idx)] <= work.data[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop && work.req == REQ_PIXEL) begin
			line_rd_s1 <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop && work.req == REQ_PAL_WR && 32'(work.idx) < PALETTE_DEPTH) begin
			pal_mem[PW'(work.idx)] <= work.data;
		end
	end

	assign colored = pix_s1 && (line_rd_s1 < PIX_W'(num_colors))
		&& (32'(line_rd_s1) < PALETTE_DEPTH);

	always_ff @(posedge clk) begin
		if (v_s1 && colored) begin
			pal_rd_s2 <= pal_mem[PW'(line_rd_s1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q     <= '0;
			row_phase_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			v_s1 <= work_pop;
			v_s2 <= v_s1;
			if (work_pop && work.req == REQ_ROW_START) begin
				lines_q     <= lines_next;
				row_phase_q <= work.phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop) begin
			take_s1 <= (work.req == REQ_ROW_START) && take;
			pix_s1  <= (work.req == REQ_PIXEL) && pat_hit;
		end
		if (v_s1) begin
			take_s2 <= take_s1;
			col_s2  <= colored;
		end
	end

	assign res_valid = v_s2;
	assign res.take  = take_s2;
	assign res.rgb   = col_s2 ? pal_rd_s2 : '0;

endmodule

// ----- rtl/core/nearest_scale_palette_colorizer.sv -----
// ----------------------------------------------------------------------------
// nearest_scale_palette_colorizer: scaled palette colorizer
// Nearest-neighbor scaling of 8-bit index pixels with palette lookup and a
// see-through screen pattern.
//
// Usage: request beats enter on the s_ channel, with the request kind in
// s_tuser (palette write, source pixel write, row start, output pixel).
// Every request beat yields exactly one result beat on the m_ channel, in
// order: RGB for output pixels, take_line in m_tuser for row starts, and
// zeros otherwise. Registers inv_scale (index 0) and num_colors (index 1)
// are written on the cfg_ channel, which is always ready; write them only
// while no request is in flight.
// Throughput is one beat per cycle while the receiver keeps up. A result
// passes from its request beat through the scale multiplier register, then
// the work queue, the line store read and the palette read, then the output queue.
// When the receiver stalls, the output queue fills and the back end stops
// drawing from the work queue; s_tready drops once the work queue, counting the record held in the front end, is full.
// Reset empties both queues, clears the line count and the row phase and
// restores inv_scale to 1.0 and num_colors to zero. Palette and line store
// hold undefined values until written.
// ----------------------------------------------------------------------------
module nearest_scale_palette_colorizer #(
	parameter int LINE_DEPTH    = nsp_pkg::LINE_DEPTH_DEF,
	parameter int PALETTE_DEPTH = nsp_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [47:0]                        s_tdata,    // index, data_value, row
	input  logic [1:0]                         s_tuser,    // req_type
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,    // red, green, blue
	output logic [0:0]                         m_tuser,    // take_line
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nsp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nsp_pkg::SCALE_W-1:0]        cfg_data
);

	import nsp_pkg::*;

	logic [SCALE_W-1:0]    inv_scale_q;
	logic [NCOL_W-1:0]     num_colors_q;

	logic                  work_valid;
	work_t                 work_in;
	work_t                 work_head;
	logic                  work_avail;
	logic                  work_pop;
	logic [MID_CNT_W-1:0]  mid_count;

	logic                  res_valid;
	res_t                  res_in;
	res_t                  res_head;
	logic                  out_pop;
	logic [OUT_CNT_W-1:0]  out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_scale_q  <= SCALE_W'(32'h10000);
			num_colors_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INV_SCALE:  inv_scale_q  <= cfg_data;
				CFG_NUM_COLORS: num_colors_q <= cfg_data[NCOL_W-1:0];
				default: ;
			endcase
		end
	end

	nsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.inv_scale  (inv_scale_q),
		.mid_count  (mid_count),
		.work_valid (work_valid),
		.work       (work_in)
	);

	nsp_fifo #(
		.DEPTH (MID_DEPTH),
		.T     (work_t)
	) u_work_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (work_valid),
		.push_data (work_in),
		.pop       (work_pop),
		.pop_data  (work_head),
		.not_empty (work_avail),
		.count     (mid_count)
	);

	nsp_back #(
		.LINE_DEPTH    (LINE_DEPTH),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_avail (work_avail),
		.work       (work_head),
		.work_pop   (work_pop),
		.num_colors (num_colors_q),
		.out_count  (out_count),
		.res_valid  (res_valid),
		.res        (res_in)
	);

	nsp_fifo #(
		.DEPTH (OUT_DEPTH),
		.T     (res_t)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_in),
		.pop       (out_pop),
		.pop_data  (res_head),
		.not_empty (m_tvalid),
		.count     (out_count)
	);

	assign out_pop = m_tvalid && m_tready;
	assign m_tdata = {res_head.rgb[7:0], res_head.rgb[15:8], res_head.rgb[23:16]};
	assign m_tuser = res_head.take;

endmodule
